// ===== design/spsf_pkg.sv =====
// Shared types for the streaming pair-sum finder.
// No dependencies; used by spsf_cell and streaming_pair_sum_finder.
package spsf_pkg;

    // Search token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic valid;
        logic hit;
        logic present;
    } t_tok;

    localparam t_tok TOK_IDLE = '{valid: 1'b0, hit: 1'b0, present: 1'b0};

endpackage

// ===== design/spsf_cell.sv =====
// One storage cell of the pair-sum finder: a stored value, its compare logic
// and one stage of the search token path. Depends on spsf_pkg.
module spsf_cell import spsf_pkg::*; #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16,
    parameter int IDX        = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic        [VALUE_BITS-1:0] i_entry,
    output logic        [VALUE_BITS-1:0] o_entry,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] i_count,
    input  logic signed   [VALUE_BITS+1:0] i_comp,
    input  logic        [VALUE_BITS-1:0] i_val,
    input  t_tok                         i_tok,
    output t_tok                         o_tok
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [VALUE_BITS-1:0] r_entry;
    t_tok                  r_tok;
    t_tok                  n_tok;
    logic                  w_live;
    logic [VALUE_BITS+1:0] w_entry_ext;

    // The cell holds a live value only below the fill count
    assign w_live      = i_count > IDX_C;
    assign w_entry_ext = {{2{r_entry[VALUE_BITS-1]}}, r_entry};

    // Fold this cell's compare results into the passing token
    always_comb begin
        n_tok         = i_tok;
        n_tok.hit     = i_tok.hit | (w_live && (w_entry_ext == i_comp));
        n_tok.present = i_tok.present | (w_live && (r_entry == i_val));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= TOK_IDLE;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Shift the stored value one cell down on insert
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule

// ===== design/streaming_pair_sum_finder.sv =====
// Top level of the streaming pair-sum finder: control sequencer, output
// register and the chain of spsf_cell storage cells. Depends on spsf_pkg.
//
// Usage: words of a sequence enter on the input channel (i_value, i_last),
// handshaken by i_in_valid / o_in_stall. For each word the block checks
// whether target_sum minus the value was seen earlier in the sequence. The
// first hit delivers one result word (found set, the value and its
// complement); later words of that sequence give nothing. A last word
// without a hit delivers a not-found result. o_overflow reports values
// dropped for lack of room. The target is written on the cfg channel.
// Timing: each word is captured, its search token is launched and walks the
// cell chain, and then the word commits; the next word is accepted only after
// the commit. Words arriving after a hit are taken without a search. A result
// is loaded into the output register at the end of the commit state.
// Reset clears the fill count, the flags and the target; stored values are
// left as they are. Input and cfg channels hold off while reset is low.
// While the receiver stalls a pending result holds; the next word is still
// searched and waits at commit only if it has a result.
module streaming_pair_sum_finder import spsf_pkg::*; #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic signed   [VALUE_BITS:0] i_cfg_data,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_last,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic signed [VALUE_BITS-1:0] o_later_value,
    output logic signed   [VALUE_BITS:0] o_earlier_value,
    output logic                         o_overflow
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LAUNCH = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FIN    = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic signed [VALUE_BITS:0]   r_target;
    logic [CW-1:0]                r_count, n_count;
    logic                         r_pair_done, n_pair_done;
    logic                         r_ovf, n_ovf;
    logic [VALUE_BITS-1:0]        r_v, n_v;
    logic signed [VALUE_BITS+1:0] r_comp, n_comp;
    logic                         r_last, n_last;
    logic                         r_hit, n_hit;
    logic                         r_present, n_present;
    logic                         r_out_valid, n_out_valid;
    logic                         r_found, n_found;
    logic [VALUE_BITS-1:0]        r_later, n_later;
    logic [VALUE_BITS:0]          r_earlier, n_earlier;
    logic                         r_out_ovf, n_out_ovf;

    logic                         w_in_acc;
    logic                         w_shift;
    logic                         w_full;
    logic                         w_emit;
    logic                         w_out_free;

    t_tok                         w_tok [MAX_ITEMS+1];
    logic [VALUE_BITS-1:0]        w_entry [MAX_ITEMS];

    assign o_cfg_ready = i_rst_n;
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_full      = r_count == CW'(MAX_ITEMS);
    assign w_emit      = r_hit || r_last;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Launch the search token into the first cell
    assign w_tok[0] = '{valid: (r_state == S_LAUNCH), hit: 1'b0, present: 1'b0};

    // Sequencer: capture, search, commit
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pair_done = r_pair_done;
        n_ovf       = r_ovf;
        n_v         = r_v;
        n_comp      = r_comp;
        n_last      = r_last;
        n_hit       = r_hit;
        n_present   = r_present;
        n_out_valid = r_out_valid && i_out_stall;
        n_found     = r_found;
        n_later     = r_later;
        n_earlier   = r_earlier;
        n_out_ovf   = r_out_ovf;
        w_shift     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_pair_done) begin
                        // drop words after a hit; a last word clears the sequence
                        if (i_last) begin
                            n_count     = '0;
                            n_pair_done = 1'b0;
                            n_ovf       = 1'b0;
                        end
                    end else begin
                        n_v     = i_value;
                        n_last  = i_last;
                        n_comp  = $signed({r_target[VALUE_BITS], r_target})
                                - $signed({{2{i_value[VALUE_BITS-1]}}, i_value});
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_tok[MAX_ITEMS].valid) begin
                    n_hit     = w_tok[MAX_ITEMS].hit;
                    n_present = w_tok[MAX_ITEMS].present;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (!w_emit || w_out_free) begin
                    n_state = S_IDLE;
                    if (w_emit) begin
                        n_out_valid = 1'b1;
                        n_found     = r_hit;
                        n_later     = r_hit ? r_v : '0;
                        n_earlier   = r_hit ? r_comp[VALUE_BITS:0] : '0;
                        n_out_ovf   = r_ovf;
                        if (r_hit) begin
                            n_pair_done = 1'b1;
                        end
                    end else if (!r_present) begin
                        // insert a new distinct value, or note the drop
                        if (w_full) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_shift = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    if (r_last) begin
                        n_count     = '0;
                        n_pair_done = 1'b0;
                        n_ovf       = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pair_done <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_target    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pair_done <= n_pair_done;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_v       <= n_v;
        r_comp    <= n_comp;
        r_last    <= n_last;
        r_hit     <= n_hit;
        r_present <= n_present;
        r_found   <= n_found;
        r_later   <= n_later;
        r_earlier <= n_earlier;
        r_out_ovf <= n_out_ovf;
    end

    // Cell chain: values shift down on insert, the token walks down each cycle
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_cell_in;
        if (g == 0) begin : g_head
            assign w_cell_in = r_v;
        end else begin : g_body
            assign w_cell_in = w_entry[g-1];
        end
        spsf_cell #(
            .MAX_ITEMS  (MAX_ITEMS),
            .VALUE_BITS (VALUE_BITS),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry (w_cell_in),
            .o_entry (w_entry[g]),
            .i_count (r_count),
            .i_comp  (r_comp),
            .i_val   (r_v),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_later_value   = r_later;
    assign o_earlier_value = r_earlier;
    assign o_overflow      = r_out_ovf;

endmodule

// ===== tb/streaming_pair_sum_finder_tb.sv =====
// Testbench for streaming_pair_sum_finder: directed and random sequences against a
// behavioral pair-sum predictor, with random sender/receiver stalls and a long output hold.
// Depends only on the RTL of the block.
module streaming_pair_sum_finder_tb;

    localparam int MAX_ITEMS     = 64;
    localparam int VALUE_BITS    = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = MAX_ITEMS + 8;
    localparam int VALUE_MIN     = -(1 << (VALUE_BITS - 1));
    localparam int VALUE_MAX     = (1 << (VALUE_BITS - 1)) - 1;
    localparam int TARGET_MIN    = -(1 << VALUE_BITS);
    localparam int TARGET_MAX    = (1 << VALUE_BITS) - 2;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic signed [VALUE_BITS:0]   t_target;

    typedef struct {
        logic    found;
        t_value  later;
        t_target earlier;
        logic    overflow;
    } t_pair_result;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_cfg_valid;
    logic    o_cfg_ready;
    t_target i_cfg_data;
    logic    i_in_valid;
    logic    o_in_stall;
    t_value  i_value;
    logic    i_last;
    logic    o_out_valid;
    logic    i_out_stall;
    logic    o_found;
    t_value  o_later_value;
    t_target o_earlier_value;
    logic    o_overflow;

    // Predictor state: one sequence at a time
    t_value       seen_vals[MAX_ITEMS];
    int           seen_count;
    bit           pair_hit;
    bit           values_dropped;
    t_target      target_q;
    t_pair_result pair_results_due[$];

    int mismatch_count;
    int useful_words;
    int seq_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_left;

    streaming_pair_sum_finder #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_value         (i_value),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_later_value   (o_later_value),
        .o_earlier_value (o_earlier_value),
        .o_overflow      (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Drive receiver stall: a long hold when requested, else random idling
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_out_stall <= 1'b1;
            rx_hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Compare each accepted result word with the oldest pending prediction
    always @(posedge i_clk) begin : check_results
        t_pair_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pair_results_due.size() == 0) begin
                $error("result word with none pending: found=%0b later=%0d earlier=%0d",
                       o_found, o_later_value, o_earlier_value);
                mismatch_count++;
            end else begin
                want = pair_results_due.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    mismatch_count++;
                end
                if (o_later_value !== want.later) begin
                    $error("later_value: expected %0d, got %0d", want.later, o_later_value);
                    mismatch_count++;
                end
                if (o_earlier_value !== want.earlier) begin
                    $error("earlier_value: expected %0d, got %0d",
                           want.earlier, o_earlier_value);
                    mismatch_count++;
                end
                if (o_overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, o_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Advance the predictor by one accepted word; queue its result, if any
    task automatic track_pair_sum(input t_value v, input logic is_last);
        int           comp;
        int           i;
        bit           hit;
        bit           present;
        t_pair_result r;
        if (!pair_hit) begin
            useful_words++;
            comp    = int'(target_q) - int'(v);
            hit     = 1'b0;
            present = 1'b0;
            for (i = 0; i < seen_count; i++) begin
                if (int'(seen_vals[i]) == comp) hit = 1'b1;
                if (seen_vals[i] == v) present = 1'b1;
            end
            if (hit) begin
                r.found    = 1'b1;
                r.later    = v;
                r.earlier  = t_target'(comp);
                r.overflow = values_dropped;
                pair_results_due.push_back(r);
                pair_hit = 1'b1;
            end else if (is_last) begin
                r.found    = 1'b0;
                r.later    = '0;
                r.earlier  = '0;
                r.overflow = values_dropped;
                pair_results_due.push_back(r);
            end else if (!present) begin
                if (seen_count < MAX_ITEMS) begin
                    seen_vals[seen_count] = v;
                    seen_count++;
                end else begin
                    values_dropped = 1'b1;
                end
            end
        end
        // Clear the sequence on its last word, hit or not
        if (is_last) begin
            seen_count     = 0;
            pair_hit       = 1'b0;
            values_dropped = 1'b0;
        end
    endtask

    // Offer one word after optional idle cycles, hold it until accepted
    task automatic send_word(input t_value v, input logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_value    <= t_value'($urandom);
            i_last     <= 1'($urandom);
        end
        // Occasionally idle long enough to land anywhere in the search
        if (tx_idle_pct > 0 && $urandom_range(7) == 0) begin
            repeat ($urandom_range(MAX_ITEMS + 4)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_last     <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        track_pair_sum(v, is_last);
    endtask

    // Drop valid, drain pending results, let the last search finish
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pair_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(input t_target t);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        target_q = t;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_value rand_value();
        case ($urandom_range(7))
            0:       return t_value'(VALUE_MIN);
            1:       return t_value'(VALUE_MAX);
            2:       return '0;
            3:       return '1;
            default: return t_value'($urandom);
        endcase
    endfunction

    function automatic t_target pick_target();
        case ($urandom_range(9))
            0:       return t_target'(TARGET_MIN);
            1:       return t_target'(TARGET_MAX);
            2:       return '0;
            default: return t_target'(int'($urandom_range(TARGET_MAX - TARGET_MIN)) + TARGET_MIN);
        endcase
    endfunction

    // Random-length sequence that mostly holds a pair at random places, words after a hit ignored
    task automatic send_pair_sequence();
        int     lo;
        int     hi;
        int     len;
        int     pos_a;
        int     pos_b;
        int     k;
        bit     broken;
        t_value a;
        t_value b;
        t_value v;
        lo     = (int'(target_q) - VALUE_MAX > VALUE_MIN) ? int'(target_q) - VALUE_MAX : VALUE_MIN;
        hi     = (int'(target_q) - VALUE_MIN < VALUE_MAX) ? int'(target_q) - VALUE_MIN : VALUE_MAX;
        a      = t_value'(lo + int'($urandom_range(hi - lo)));
        b      = t_value'(int'(target_q) - int'(a));
        len    = $urandom_range(10, 2);
        pos_a  = $urandom_range(len - 2, 0);
        pos_b  = $urandom_range(len - 1, pos_a + 1);
        broken = ($urandom_range(7) == 0);
        for (k = 0; k < len; k++) begin
            if (k == pos_a) v = a;
            else if (k == pos_b && !broken) v = b;
            else if ($urandom_range(3) == 0) v = a;
            else v = rand_value();
            send_word(v, k == len - 1);
        end
    endtask

    task automatic send_noise_sequence();
        int len;
        int k;
        len = $urandom_range(12, 1);
        for (k = 0; k < len; k++) send_word(rand_value(), k == len - 1);
    endtask

    // Fill the store past capacity with values that cannot pair among themselves,
    // sprinkle duplicates, then close with the partner of a stored or a dropped value when it is in range
    task automatic send_overflow_sequence();
        int distinct;
        int stride;
        int first;
        int k;
        int partner;
        int vals[$];
        distinct = MAX_ITEMS + $urandom_range(6, 1);
        stride   = $urandom_range(15, 1);
        if (target_q >= 0) first = VALUE_MIN + int'($urandom_range(1000));
        else first = VALUE_MAX - int'($urandom_range(1000));
        for (k = 0; k < distinct; k++) begin
            vals.push_back((target_q >= 0) ? first + k * stride : first - k * stride);
            send_word(t_value'(vals[k]), 1'b0);
            if ($urandom_range(5) == 0) send_word(t_value'(vals[$urandom_range(k)]), 1'b0);
        end
        partner = int'(target_q) - vals[$urandom_range(distinct - 1)];
        if (partner >= VALUE_MIN && partner <= VALUE_MAX) send_word(t_value'(partner), 1'b1);
        else send_word(rand_value(), 1'b1);
    endtask

    // Reset target of zero: pairs, ignored words, self pairing, duplicates
    task automatic test_directed_pairs();
        send_word(16'sd5, 1'b0);
        send_word(16'sd7, 1'b0);
        send_word(-16'sd5, 1'b0);
        send_word(16'sd9, 1'b0);
        send_word(16'sd1, 1'b1);
        send_word(16'sd3, 1'b1);
        send_word(16'sd0, 1'b0);
        send_word(16'sd0, 1'b1);
        send_word(16'sd8, 1'b0);
        send_word(16'sd8, 1'b0);
        send_word(-16'sd8, 1'b1);
    endtask

    // Extreme targets, extreme values and complements out of range
    task automatic test_extreme_targets();
        wait_idle();
        write_target(t_target'(TARGET_MIN));
        send_word(t_value'(VALUE_MIN), 1'b0);
        send_word(t_value'(VALUE_MAX), 1'b0);
        send_word(t_value'(VALUE_MIN), 1'b1);
        wait_idle();
        write_target(t_target'(TARGET_MAX));
        send_word(t_value'(VALUE_MIN), 1'b0);
        send_word(t_value'(VALUE_MAX), 1'b0);
        send_word(t_value'(VALUE_MAX), 1'b1);
        wait_idle();
        write_target('1);
        send_word(t_value'(VALUE_MIN), 1'b0);
        send_word(t_value'(VALUE_MAX), 1'b1);
    endtask

    // Hold the receiver off while short found-sequences keep coming
    task automatic test_output_backpressure();
        int     k;
        t_value a;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_idle();
        write_target(t_target'(100));
        rx_hold_left = HOLD_CYCLES;
        for (k = 0; k < 12; k++) begin
            a = t_value'(int'($urandom_range(200)) - 100);
            send_word(a, 1'b0);
            send_word(t_value'(100 - int'(a)), 1'b1);
        end
    endtask

    task automatic test_random_sequences(input int tx_pct, input int rx_pct, input int words);
        int stop_at;
        int kind;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = useful_words + words;
        wait_idle();
        write_target(pick_target());
        while (useful_words < stop_at) begin
            if (seq_count % 25 == 24) begin
                wait_idle();
                write_target(pick_target());
            end
            kind = $urandom_range(99);
            if (kind < 64) send_pair_sequence();
            else if (kind < 80) send_noise_sequence();
            else if (kind < 84) send_overflow_sequence();
            else send_word(rand_value(), 1'b1);
            seq_count++;
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_value        = '0;
        i_last         = 1'b0;
        i_out_stall    = 1'b0;
        target_q       = '0;
        seen_count     = 0;
        pair_hit       = 1'b0;
        values_dropped = 1'b0;
        mismatch_count = 0;
        useful_words   = 0;
        seq_count      = 0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_left   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_pairs();
        test_extreme_targets();
        test_output_backpressure();
        test_random_sequences(15, 74, 500);
        test_random_sequences(74, 15, 500);
        test_random_sequences(0, 0, 500);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #16000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
